>>> sv/tcd_pkg.sv
// Shared types, constants and reset values for the tilt conditioner.
package tcd_pkg;

  // Samples summed before offsets are fixed
  localparam int CAL_SAMPLES = 100;
  localparam int CNT_W       = $clog2(CAL_SAMPLES + 1);

  // Sum magnitude bound: 255 samples of 32768 stay below 2**23
  localparam int SUM_W       = 24;
  localparam int SUM_MAG_W   = SUM_W - 1;

  // Divide by CAL_SAMPLES as multiply by a rounded-up reciprocal and shift
  localparam int DIV_SHIFT   = SUM_MAG_W + $clog2(CAL_SAMPLES);
  localparam int RECIP_W     = SUM_MAG_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
  localparam int PROD_W      = SUM_MAG_W + RECIP_W;

  // Queue between front and back
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam logic [1:0] REG_ALPHA    = 2'd0;
  localparam logic [1:0] REG_DEADBAND = 2'd1;
  localparam logic [1:0] REG_ONE_G    = 2'd2;
  localparam logic [1:0] REG_TIMEOUT  = 2'd3;

  // Configuration reset values
  localparam logic [15:0] ALPHA_RST    = 16'd16384;
  localparam logic [14:0] DEADBAND_RST = 15'd100;
  localparam logic [14:0] ONE_G_RST    = 15'd16384;
  localparam logic [7:0]  TIMEOUT_RST  = 8'd5;

  // Unity gain in Q15
  localparam logic [15:0] ALPHA_ONE    = 16'd32768;
  localparam int          Q_FRAC       = 15;

  // Input commands
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_DONE     = 2'd1;
  localparam logic [1:0] CMD_BUS_ERR  = 2'd2;
  localparam logic [1:0] CMD_RESTART  = 2'd3;

  // Work passed from front to back
  typedef enum logic [1:0] {
    OP_NONE,
    OP_SAMPLE,
    OP_BUS_ERR,
    OP_RESTART
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               start;
    logic               abort;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } qent_t;

  // Registers the back part needs
  typedef struct packed {
    logic [15:0] alpha;
    logic [14:0] deadband;
    logic [14:0] one_g;
  } back_cfg_t;

endpackage

>>> sv/tcd_front.sv
// Front part: accepts items, runs the read/timeout tracker and classifies work.
module tcd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  input  logic signed [15:0]   in_raw_x,
  input  logic signed [15:0]   in_raw_y,
  input  logic signed [15:0]   in_raw_z,
  input  logic [7:0]           timeout_ticks,
  input  logic                 q_full,
  output logic                 q_push,
  output tcd_pkg::qent_t       q_wdata
);
  import tcd_pkg::*;

  logic       busy_r, busy_nxt;
  logic [7:0] busy_cnt_r, busy_cnt_nxt;
  logic [7:0] cnt_inc;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign cnt_inc  = busy_cnt_r + 8'd1;

  // Classify the command and advance the read tracker
  always_comb begin
    busy_nxt      = busy_r;
    busy_cnt_nxt  = busy_cnt_r;
    q_wdata.op    = OP_NONE;
    q_wdata.start = 1'b0;
    q_wdata.abort = 1'b0;
    q_wdata.x     = in_raw_x;
    q_wdata.y     = in_raw_y;
    q_wdata.z     = in_raw_z;
    unique case (in_command)
      CMD_TICK: begin
        if (busy_r) begin
          busy_cnt_nxt = cnt_inc;
          if (cnt_inc >= timeout_ticks) begin
            q_wdata.abort = 1'b1;
            busy_nxt      = 1'b0;
            busy_cnt_nxt  = 8'd0;
          end
        end else begin
          q_wdata.start = 1'b1;
          busy_nxt      = 1'b1;
          busy_cnt_nxt  = 8'd0;
        end
      end
      CMD_DONE: begin
        // a completion with no read outstanding carries no sample
        if (busy_r) begin
          q_wdata.op   = OP_SAMPLE;
          busy_nxt     = 1'b0;
          busy_cnt_nxt = 8'd0;
        end
      end
      CMD_BUS_ERR: begin
        q_wdata.op   = OP_BUS_ERR;
        busy_nxt     = 1'b0;
        busy_cnt_nxt = 8'd0;
      end
      CMD_RESTART: begin
        q_wdata.op = OP_RESTART;
      end
      default: begin
        q_wdata.op = OP_NONE;
      end
    endcase
  end

  // Hold tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      busy_cnt_r <= 8'd0;
    end else if (q_push) begin
      busy_r     <= busy_nxt;
      busy_cnt_r <= busy_cnt_nxt;
    end
  end

endmodule

>>> sv/tcd_queue.sv
// Short FIFO between the front and back parts.
module tcd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcd_pkg::qent_t wdata,
  input  logic           pop,
  output tcd_pkg::qent_t rdata,
  output logic           full,
  output logic           empty
);
  import tcd_pkg::*;

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Transfers never overrun or underrun
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  assert property (@(posedge clk) disable iff (!rst_n) (push && !pop) |-> !full)
    else $error("queue push while full");

endmodule

>>> sv/tcd_back.sv
// Back part: calibration sums, offset divide, EMA, deadband and result register.
module tcd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcd_pkg::back_cfg_t   cfg,
  input  logic                 q_empty,
  input  tcd_pkg::qent_t       q_rdata,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_tilt_x,
  output logic signed [15:0]   out_tilt_y,
  output logic                 out_start_read,
  output logic                 out_abort_read,
  output logic                 out_calibrating
);
  import tcd_pkg::*;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  // Calibration state
  logic                    in_cal_r, in_cal_nxt;
  logic [CNT_W-1:0]        cal_cnt_r, cal_cnt_nxt, cnt_inc;
  logic signed [SUM_W-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic signed [SUM_W-1:0] sum_x_nxt, sum_y_nxt, sum_z_nxt;
  logic signed [15:0]      off_x_r, off_y_r, off_z_r;
  // Filter state
  logic signed [16:0]      avg_x_r, avg_y_r, avg_x_nxt, avg_y_nxt;
  logic signed [15:0]      pub_x_r, pub_y_r, pub_x_nxt, pub_y_nxt;
  // Offset divide sequencer
  logic                    div_act_r, div_act_nxt;
  axis_t                   div_sel_r, div_sel_nxt;
  // Result register
  logic                    out_valid_r, start_r, abort_r;

  logic                    cal_done;
  logic [15:0]             alpha_sat;
  logic signed [15:0]      cx, cy;

  // Divider datapath
  logic signed [SUM_W-1:0] div_in;
  logic                    div_neg;
  logic [SUM_W-1:0]        div_abs;
  logic [PROD_W-1:0]       div_prod;
  logic [16:0]             q_mag;
  logic signed [16:0]      q_sgn;
  logic signed [17:0]      z_off;

  // EMA step: avg + floor(a * (sample - avg) / 2**15)
  function automatic logic signed [16:0] ema_step(
    input logic signed [16:0] avg,
    input logic signed [15:0] smp,
    input logic [15:0]        a
  );
    logic signed [17:0] err;
    logic signed [16:0] a_s;
    logic signed [34:0] prod;
    logic signed [19:0] d;
    logic signed [19:0] acc;
    err  = 18'(smp) - 18'(avg);
    a_s  = $signed({1'b0, a});
    prod = 35'(a_s) * 35'(err);
    d    = prod[34:Q_FRAC];
    acc  = 20'(avg) + d;
    return acc[16:0];
  endfunction

  // Zero values whose magnitude is strictly under the deadband
  function automatic logic signed [15:0] dead_zone(
    input logic signed [15:0] v,
    input logic [14:0]        db
  );
    logic signed [16:0] vv;
    logic signed [16:0] dbs;
    vv  = 17'(v);
    dbs = $signed({2'b00, db});
    return (vv > -dbs && vv < dbs) ? 16'sd0 : v;
  endfunction

  assign q_pop     = !q_empty && !div_act_r && (!out_valid_r || out_ready);
  assign alpha_sat = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
  assign cx        = q_rdata.x - off_x_r;
  assign cy        = q_rdata.y - off_y_r;
  assign cnt_inc   = cal_cnt_r + 1'b1;
  assign cal_done  = (cnt_inc == CNT_W'(CAL_SAMPLES));

  // Select a sum and divide it by the sample count, truncating toward zero
  always_comb begin
    case (div_sel_r)
      AX_X:    div_in = sum_x_r;
      AX_Y:    div_in = sum_y_r;
      default: div_in = sum_z_r;
    endcase
    div_neg  = div_in[SUM_W-1];
    div_abs  = div_neg ? SUM_W'(-div_in) : SUM_W'(div_in);
    div_prod = PROD_W'(div_abs[SUM_MAG_W-1:0]) * PROD_W'(RECIP);
    q_mag    = 17'(div_prod >> DIV_SHIFT);
    q_sgn    = div_neg ? -$signed(q_mag) : $signed(q_mag);
    z_off    = 18'(q_sgn) - $signed({3'b000, cfg.one_g});
  end

  // Work out the next state for the popped entry
  always_comb begin
    in_cal_nxt  = in_cal_r;
    cal_cnt_nxt = cal_cnt_r;
    sum_x_nxt   = sum_x_r;
    sum_y_nxt   = sum_y_r;
    sum_z_nxt   = sum_z_r;
    avg_x_nxt   = avg_x_r;
    avg_y_nxt   = avg_y_r;
    pub_x_nxt   = pub_x_r;
    pub_y_nxt   = pub_y_r;
    div_act_nxt = 1'b0;
    div_sel_nxt = AX_X;
    unique case (q_rdata.op)
      OP_SAMPLE: begin
        if (in_cal_r) begin
          sum_x_nxt   = sum_x_r + SUM_W'(q_rdata.x);
          sum_y_nxt   = sum_y_r + SUM_W'(q_rdata.y);
          sum_z_nxt   = sum_z_r + SUM_W'(q_rdata.z);
          cal_cnt_nxt = cnt_inc;
          if (cal_done) begin
            in_cal_nxt  = 1'b0;
            cal_cnt_nxt = '0;
            avg_x_nxt   = '0;
            avg_y_nxt   = '0;
            pub_x_nxt   = '0;
            pub_y_nxt   = '0;
            div_act_nxt = 1'b1;
          end
        end else begin
          avg_x_nxt = ema_step(avg_x_r, cx, alpha_sat);
          avg_y_nxt = ema_step(avg_y_r, cy, alpha_sat);
          pub_x_nxt = dead_zone(avg_x_nxt[15:0], cfg.deadband);
          pub_y_nxt = dead_zone(avg_y_nxt[15:0], cfg.deadband);
        end
      end
      OP_BUS_ERR: begin
        // an error mid-calibration starts the count over
        if (in_cal_r) begin
          cal_cnt_nxt = '0;
          sum_x_nxt   = '0;
          sum_y_nxt   = '0;
          sum_z_nxt   = '0;
        end
      end
      OP_RESTART: begin
        in_cal_nxt  = 1'b1;
        cal_cnt_nxt = '0;
        sum_x_nxt   = '0;
        sum_y_nxt   = '0;
        sum_z_nxt   = '0;
      end
      default: begin
        in_cal_nxt = in_cal_r;
      end
    endcase
  end

  // Hold state, run the divide sequencer and load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cal_r    <= 1'b1;
      cal_cnt_r   <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      off_x_r     <= '0;
      off_y_r     <= '0;
      off_z_r     <= '0;
      avg_x_r     <= '0;
      avg_y_r     <= '0;
      pub_x_r     <= '0;
      pub_y_r     <= '0;
      div_act_r   <= 1'b0;
      div_sel_r   <= AX_X;
      out_valid_r <= 1'b0;
      start_r     <= 1'b0;
      abort_r     <= 1'b0;
    end else begin
      if (div_act_r) begin
        case (div_sel_r)
          AX_X: begin
            off_x_r   <= q_sgn[15:0];
            div_sel_r <= AX_Y;
          end
          AX_Y: begin
            off_y_r   <= q_sgn[15:0];
            div_sel_r <= AX_Z;
          end
          default: begin
            off_z_r   <= z_off[15:0];
            div_sel_r <= AX_X;
            div_act_r <= 1'b0;
          end
        endcase
      end
      if (q_pop) begin
        in_cal_r    <= in_cal_nxt;
        cal_cnt_r   <= cal_cnt_nxt;
        sum_x_r     <= sum_x_nxt;
        sum_y_r     <= sum_y_nxt;
        sum_z_r     <= sum_z_nxt;
        avg_x_r     <= avg_x_nxt;
        avg_y_r     <= avg_y_nxt;
        pub_x_r     <= pub_x_nxt;
        pub_y_r     <= pub_y_nxt;
        div_act_r   <= div_act_nxt;
        div_sel_r   <= div_sel_nxt;
        out_valid_r <= 1'b1;
        start_r     <= q_rdata.start;
        abort_r     <= q_rdata.abort;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tilt_x      = pub_x_r;
  assign out_tilt_y      = pub_y_r;
  assign out_start_read  = start_r;
  assign out_abort_read  = abort_r;
  assign out_calibrating = in_cal_r;

  // No entry is taken while offsets are still being computed
  assert property (@(posedge clk) disable iff (!rst_n) div_act_r |-> !q_pop)
    else $error("entry taken during offset divide");
  // Closing calibration publishes zero tilt and drops the flag
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && in_cal_r && q_rdata.op == OP_SAMPLE && cal_done) |=>
      (!in_cal_r && pub_x_r == 16'sd0 && pub_y_r == 16'sd0 && div_act_r))
    else $error("calibration end not applied");
  // The sample count is idle outside calibration
  assert property (@(posedge clk) disable iff (!rst_n) !in_cal_r |-> cal_cnt_r == '0)
    else $error("sample count running outside calibration");

endmodule

>>> sv/tilt_calibrate_ema_deadband.sv
// Top level of the tilt conditioner: configuration registers and part wiring.
//
//   channel  direction  handshake                 payload
//   in_      sink       in_valid / in_ready       command, raw_x, raw_y, raw_z
//   out_     source     out_valid / out_ready     tilt_x, tilt_y, start_read,
//                                                 abort_read, calibrating
//   cfg_     sink       cfg_we (no wait)          cfg_index, cfg_data
//
// One item in and one result out per cycle when neither side stalls. An item
// passes from the front into the queue and from the queue through the back into
// the result register. The sample that closes calibration holds the back part
// while the three offsets pass one at a time through the shared reciprocal
// multiplier. A stalled result only holds the back part; the front keeps taking
// items until the two-entry queue fills. Reset is synchronous and active low and
// restores all registers but the queue storage to their start values.
module tilt_calibrate_ema_deadband (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_command,
  input  logic signed [15:0]   in_raw_x,
  input  logic signed [15:0]   in_raw_y,
  input  logic signed [15:0]   in_raw_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_tilt_x,
  output logic signed [15:0]   out_tilt_y,
  output logic                 out_start_read,
  output logic                 out_abort_read,
  output logic                 out_calibrating,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import tcd_pkg::*;

  logic [15:0] alpha_r;
  logic [14:0] deadband_r;
  logic [14:0] one_g_r;
  logic [7:0]  timeout_r;

  back_cfg_t   back_cfg;
  qent_t       q_wdata, q_rdata;
  logic        q_push, q_pop, q_full, q_empty;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r    <= ALPHA_RST;
      deadband_r <= DEADBAND_RST;
      one_g_r    <= ONE_G_RST;
      timeout_r  <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA:    alpha_r    <= cfg_data;
        REG_DEADBAND: deadband_r <= cfg_data[14:0];
        REG_ONE_G:    one_g_r    <= cfg_data[14:0];
        REG_TIMEOUT:  timeout_r  <= cfg_data[7:0];
        default:      alpha_r    <= alpha_r;
      endcase
    end
  end

  assign back_cfg.alpha    = alpha_r;
  assign back_cfg.deadband = deadband_r;
  assign back_cfg.one_g    = one_g_r;

  tcd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_raw_x      (in_raw_x),
    .in_raw_y      (in_raw_y),
    .in_raw_z      (in_raw_z),
    .timeout_ticks (timeout_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  tcd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  tcd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (back_cfg),
    .q_empty         (q_empty),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tilt_x      (out_tilt_x),
    .out_tilt_y      (out_tilt_y),
    .out_start_read  (out_start_read),
    .out_abort_read  (out_abort_read),
    .out_calibrating (out_calibrating)
  );

endmodule
